[hdl/tcw_pkg.sv]
// shared constants, item kinds and the queue entry type for the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // internal widths follow the geometry
    localparam int ROW_IW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_IW = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);

    // port field widths
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int RIDX_W     = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int POS_OUT_W  = 11;
    localparam int CELL_W     = 16;
    localparam int SCNT_W     = 32;
    localparam int COLOR_W    = 8;

    // character and attribute codes
    localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0]  CH_BLANK    = 8'h20;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;
    localparam int                 TAB_EXTRA   = 5;
    localparam int                 TAB_STEP    = TAB_EXTRA + 1;

    // command codes on the input port
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BKSP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // what the front decided an item is
    typedef enum logic [2:0] {
        K_PUT   = 3'd0,
        K_NL    = 3'd1,
        K_TAB   = 3'd2,
        K_BKSP  = 3'd3,
        K_CLEAR = 3'd4,
        K_READ  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CHAR_W-1:0]   ch;
        logic [RIDX_W-1:0]   ridx;
    } t_op;

endpackage

`default_nettype wire

[hdl/tcw_front.sv]
// front part: takes input beats, classifies them and hands them to the queue
`timescale 1ns / 1ps
`default_nettype none

module tcw_front import tcw_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic [RIDX_W-1:0] i_read_index,
    input  wire logic              i_hold,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_op                    o_push_op
);

    logic  r_op_valid;
    logic  n_op_valid;
    t_op   r_op;
    t_op   op_class;
    logic  accept;

    always_comb begin
        op_class.ch   = i_char_code;
        op_class.ridx = i_read_index;
        op_class.kind = K_PUT;
        unique case (i_command)
            CMD_PUT: begin
                priority if (i_char_code == CH_NEWLINE) begin
                    op_class.kind = K_NL;
                end else if (i_char_code == CH_TAB) begin
                    op_class.kind = K_TAB;
                end else begin
                    op_class.kind = K_PUT;
                end
            end
            CMD_BKSP:  op_class.kind = K_BKSP;
            CMD_CLEAR: op_class.kind = K_CLEAR;
            CMD_READ:  op_class.kind = K_READ;
            default:   op_class.kind = K_PUT;
        endcase
    end

    assign o_push     = r_op_valid && !i_q_full;
    assign o_push_op  = r_op;
    assign o_in_stall = i_hold || (r_op_valid && i_q_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign n_op_valid = accept || (r_op_valid && !o_push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_valid <= 1'b0;
        end else begin
            r_op_valid <= n_op_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= op_class;
        end
    end

endmodule

`default_nettype wire

[hdl/tcw_queue.sv]
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue import tcw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_push_op,
    output logic      o_full,
    output logic      o_valid,
    output t_op       o_op,
    input  wire logic i_pop
);

    t_op               r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_head;
    logic [QPTR_W-1:0] n_tail;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail = (r_tail == QPTR_W'(QDEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (do_pop) begin
            n_head = (r_head == QPTR_W'(QDEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_tail] <= i_push_op;
        end
    end

endmodule

`default_nettype wire

[hdl/tcw_back.sv]
// back part: cursor state, screen store, scroll and fill sweeps, result register
`timescale 1ns / 1ps
`default_nettype none

module tcw_back import tcw_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [COLOR_W-1:0] i_cfg_wr_data,
    input  wire logic               i_q_valid,
    input  wire t_op                i_q_op,
    output logic                    o_q_pop,
    output logic                    o_init_busy,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [ROW_OUT_W-1:0]    o_cursor_row,
    output logic [COL_OUT_W-1:0]    o_cursor_col,
    output logic [POS_OUT_W-1:0]    o_cursor_pos,
    output logic [CELL_W-1:0]       o_cell_data,
    output logic [SCNT_W-1:0]       o_scroll_count
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SCROLL = 5'b00100,
        S_FILL   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_bstate;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IW-1:0] row,
                                                    input logic [COL_IW-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
    endfunction

    t_bstate              r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [ROW_IW-1:0]    r_row, n_row;
    logic [COL_IW-1:0]    r_col, n_col;
    logic [SCNT_W-1:0]    r_scrolls, n_scrolls;
    logic [CELL_W-1:0]    r_cell, n_cell;
    logic                 r_init, n_init;
    logic [COLOR_W-1:0]   r_text_color;

    logic [CELL_W-1:0]    r_mem [CELL_COUNT];
    logic [CELL_W-1:0]    r_rdata;
    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_wa, mem_ra;
    logic [CELL_W-1:0]    mem_wd;

    logic                 r_out_valid;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [COL_OUT_W-1:0] r_out_col;
    logic [POS_OUT_W-1:0] r_out_pos;
    logic [CELL_W-1:0]    r_out_cell;
    logic [SCNT_W-1:0]    r_out_scrolls;
    logic                 out_free;
    logic                 load;

    logic [CELL_W-1:0]    blank;
    logic [ADDR_W-1:0]    cur_addr;
    logic                 last_row;
    logic [COL_IW:0]      col_adv;
    logic                 col_wrap;
    logic [ROW_IW-1:0]    bs_row;
    logic [COL_IW-1:0]    bs_col;
    logic                 read_ok;
    logic [CNT_W-1:0]     cnt_ahead;
    logic [CNT_W-1:0]     cnt_back;

    assign blank     = {r_text_color, CH_BLANK};
    assign cur_addr  = cell_addr(r_row, r_col);
    assign last_row  = (r_row == ROW_IW'(ROWS - 1));
    assign col_adv   = {1'b0, r_col} +
                       ((i_q_op.kind == K_TAB) ? (COL_IW+1)'(TAB_STEP) : (COL_IW+1)'(1));
    assign col_wrap  = (col_adv >= (COL_IW+1)'(COLUMNS));
    assign read_ok   = (32'(i_q_op.ridx) < 32'(CELL_COUNT));
    assign cnt_ahead = r_cnt + CNT_W'(COLUMNS);
    assign cnt_back  = r_cnt - 1'b1;
    assign out_free  = !r_out_valid || !i_out_stall;

    // backspace target: step left, wrap to end of previous row, hold at origin
    always_comb begin
        bs_row = r_row;
        bs_col = r_col;
        priority if (r_col != '0) begin
            bs_col = r_col - 1'b1;
        end else if (r_row != '0) begin
            bs_row = r_row - 1'b1;
            bs_col = COL_IW'(COLUMNS - 1);
        end else begin
            bs_col = r_col;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_row     = r_row;
        n_col     = r_col;
        n_scrolls = r_scrolls;
        n_cell    = r_cell;
        n_init    = r_init;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        mem_re    = 1'b0;
        mem_ra    = '0;
        o_q_pop   = 1'b0;
        load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cell  = '0;
                    n_state = S_EMIT;
                    unique case (i_q_op.kind)
                        K_PUT, K_TAB: begin
                            if (i_q_op.kind == K_PUT) begin
                                mem_we = 1'b1;
                                mem_wa = cur_addr;
                                mem_wd = {r_text_color, i_q_op.ch};
                            end
                            if (col_wrap) begin
                                n_col = '0;
                                if (last_row) begin
                                    n_state = S_SCROLL;
                                    n_cnt   = '0;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = col_adv[COL_IW-1:0];
                            end
                        end
                        K_NL: begin
                            n_col = '0;
                            if (last_row) begin
                                n_state   = S_SCROLL;
                                n_cnt     = '0;
                                n_scrolls = r_scrolls + 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end
                        K_BKSP: begin
                            n_row  = bs_row;
                            n_col  = bs_col;
                            mem_we = 1'b1;
                            mem_wa = cell_addr(bs_row, bs_col);
                            mem_wd = blank;
                        end
                        K_CLEAR: begin
                            n_state = S_FILL;
                            n_cnt   = '0;
                        end
                        K_READ: begin
                            if (read_ok) begin
                                mem_re  = 1'b1;
                                mem_ra  = ADDR_W'(i_q_op.ridx);
                                n_state = S_READ;
                            end
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_READ: begin
                n_cell  = r_rdata;
                n_state = S_EMIT;
            end
            S_SCROLL: begin
                // read one row ahead, write the cell fetched the cycle before
                if (r_cnt < CNT_W'(CELL_COUNT - COLUMNS)) begin
                    mem_re = 1'b1;
                    mem_ra = cnt_ahead[ADDR_W-1:0];
                end
                if (r_cnt != '0) begin
                    mem_we = 1'b1;
                    mem_wa = cnt_back[ADDR_W-1:0];
                    mem_wd = (cnt_back < CNT_W'(CELL_COUNT - COLUMNS)) ? r_rdata : blank;
                end
                if (r_cnt == CNT_W'(CELL_COUNT)) begin
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                mem_wa = r_cnt[ADDR_W-1:0];
                mem_wd = blank;
                if (r_cnt == CNT_W'(CELL_COUNT - 1)) begin
                    n_state = r_init ? S_IDLE : S_EMIT;
                    n_init  = 1'b0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_cnt        <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_scrolls    <= '0;
            r_init       <= 1'b1;
            r_text_color <= COLOR_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_row     <= n_row;
            r_col     <= n_col;
            r_scrolls <= n_scrolls;
            r_init    <= n_init;
            if (i_cfg_wr_en) begin
                r_text_color <= i_cfg_wr_data;
            end
            r_out_valid <= load || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (load) begin
            r_out_row     <= ROW_OUT_W'(r_row);
            r_out_col     <= COL_OUT_W'(r_col);
            r_out_pos     <= POS_OUT_W'(cur_addr);
            r_out_cell    <= r_cell;
            r_out_scrolls <= r_scrolls;
        end
    end

    // screen store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    assign o_init_busy    = r_init;
    assign o_out_valid    = r_out_valid;
    assign o_cursor_row   = r_out_row;
    assign o_cursor_col   = r_out_col;
    assign o_cursor_pos   = r_out_pos;
    assign o_cell_data    = r_out_cell;
    assign o_scroll_count = r_out_scrolls;

`ifndef NO_ASSERTIONS
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_IW'(ROWS - 1)) && (r_col <= COL_IW'(COLUMNS - 1)))
        else $error("cursor left the screen");

    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (r_state == S_FILL) && !r_out_valid)
        else $error("activity during the power-up clearing pass");

    a_scroll_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_scrolls != $past(r_scrolls)))
        |-> (r_scrolls == $past(r_scrolls) + 1'b1) && (r_state == S_SCROLL))
        else $error("scroll count moved without a newline scroll");

    a_no_write_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) || (r_state == S_READ)) |-> !mem_we)
        else $error("store written while a result is pending");
`endif

endmodule

`default_nettype wire

[hdl/text_console_writer.sv]
// top level of the text console writer: front, queue and back
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                      direction
// in        i_in_valid, o_in_stall, i_command,           item beats in
//           i_char_code, i_read_index
// out       o_out_valid, i_out_stall, o_cursor_row,      result beats out
//           o_cursor_col, o_cursor_pos, o_cell_data, o_scroll_count
// cfg       i_cfg_wr_en, i_cfg_wr_data                   text color write
//
// plain characters, tab, newline and backspace that cause no scroll go from idle
// straight to the result state in the back part; a read in range passes a read
// state first, for the registered store read port; a scroll walks the store once,
// one cell a cycle, and clear fills the store one cell a cycle; after reset a
// clearing pass over all ROWS*COLUMNS cells runs with o_in_stall high; input beats
// keep queueing while the back part is busy or its result stalls, until the queue fills

module text_console_writer import tcw_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // item channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [CMD_W-1:0]   i_command,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [RIDX_W-1:0]  i_read_index,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [ROW_OUT_W-1:0]    o_cursor_row,
    output logic [COL_OUT_W-1:0]    o_cursor_col,
    output logic [POS_OUT_W-1:0]    o_cursor_pos,
    output logic [CELL_W-1:0]       o_cell_data,
    output logic [SCNT_W-1:0]       o_scroll_count,
    // text color register
    input  wire logic               i_cfg_wr_en,
    input  wire logic [COLOR_W-1:0] i_cfg_wr_data
);

    // front to queue
    logic push;
    t_op  push_op;
    logic q_full;
    // queue to back
    logic q_valid;
    t_op  q_op;
    logic q_pop;
    // back holds off the front during the power-up clear
    logic init_busy;

    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .i_hold       (init_busy),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_op    (push_op)
    );

    // short queue so a long scroll or clear does not block the input side until it fills
    tcw_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_op      (q_op),
        .i_pop     (q_pop)
    );

    // cursor, store and result register live in the back part
    tcw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_q_valid      (q_valid),
        .i_q_op         (q_op),
        .o_q_pop        (q_pop),
        .o_init_busy    (init_busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_pos   (o_cursor_pos),
        .o_cell_data    (o_cell_data),
        .o_scroll_count (o_scroll_count)
    );

endmodule

`default_nettype wire

[tb/console_tracker_pkg.sv]
// screen tracker class: predicts the console writer's result beats and checks them
`timescale 1ns / 1ps

package console_tracker_pkg;
    import tcw_pkg::*;

    // one result beat as it leaves the block
    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [POS_OUT_W-1:0] pos;
        logic [CELL_W-1:0]    cell_data;
        logic [SCNT_W-1:0]    scrolls;
    } cursor_report_t;

    class screen_tracker;
        localparam int PRINT_CAP = 50;

        logic [CELL_W-1:0]  cells [CELL_COUNT];
        int unsigned        row;
        int unsigned        col;
        logic [SCNT_W-1:0]  nl_scrolls;
        int unsigned        wrap_scrolls;
        logic [COLOR_W-1:0] color;
        cursor_report_t     reports_due[$];
        int unsigned        items_taken;
        int unsigned        reports_seen;
        int unsigned        mismatches;

        function new();
            color        = COLOR_RESET;
            row          = 0;
            col          = 0;
            nl_scrolls   = '0;
            wrap_scrolls = 0;
            items_taken  = 0;
            reports_seen = 0;
            mismatches   = 0;
            blank_all();
        endfunction

        function void blank_all();
            for (int i = 0; i < CELL_COUNT; i++) cells[i] = {color, CH_BLANK};
        endfunction

        // column 0 of the next row; scrolls at the bottom, returns 1 if it did
        function bit next_line();
            col = 0;
            row++;
            if (row >= ROWS) begin
                for (int i = 0; i < CELL_COUNT - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                    cells[i] = {color, CH_BLANK};
                row = ROWS - 1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // apply one accepted command and queue the beat it must produce
        function void take_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                input logic [RIDX_W-1:0] ridx);
            cursor_report_t r;
            logic [CELL_W-1:0] seen;
            seen = '0;
            items_taken++;
            case (cmd)
                CMD_PUT: begin
                    if (ch == CH_NEWLINE) begin
                        if (next_line()) nl_scrolls++;
                    end else begin
                        if (ch == CH_TAB) col += TAB_EXTRA;
                        else cells[row * COLUMNS + col] = {color, ch};
                        col++;
                        if (col >= COLUMNS && next_line()) wrap_scrolls++;
                    end
                end
                CMD_BKSP: begin
                    if (col > 0) begin
                        col--;
                    end else if (row > 0) begin
                        row--;
                        col = COLUMNS - 1;
                    end
                    cells[row * COLUMNS + col] = {color, CH_BLANK};
                end
                CMD_CLEAR: blank_all();
                CMD_READ: if (ridx < CELL_COUNT) seen = cells[ridx];
            endcase
            r.row       = ROW_OUT_W'(row);
            r.col       = COL_OUT_W'(col);
            r.pos       = POS_OUT_W'(row * COLUMNS + col);
            r.cell_data = seen;
            r.scrolls   = nl_scrolls;
            reports_due.push_back(r);
        endfunction

        task report_mismatch(input string what);
            if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH %s", $time, what);
            mismatches++;
        endtask

        task check_report(input cursor_report_t got);
            cursor_report_t want;
            if (reports_due.size() == 0) begin
                report_mismatch("result beat with no command outstanding");
                return;
            end
            want = reports_due.pop_front();
            reports_seen++;
            if (got.row !== want.row)
                report_mismatch($sformatf("beat %0d cursor_row got %0d want %0d",
                                          reports_seen, got.row, want.row));
            if (got.col !== want.col)
                report_mismatch($sformatf("beat %0d cursor_col got %0d want %0d",
                                          reports_seen, got.col, want.col));
            if (got.pos !== want.pos)
                report_mismatch($sformatf("beat %0d cursor_pos got %0d want %0d",
                                          reports_seen, got.pos, want.pos));
            if (got.cell_data !== want.cell_data)
                report_mismatch($sformatf("beat %0d cell_data got %h want %h",
                                          reports_seen, got.cell_data, want.cell_data));
            if (got.scrolls !== want.scrolls)
                report_mismatch($sformatf("beat %0d scroll_count got %0d want %0d",
                                          reports_seen, got.scrolls, want.scrolls));
        endtask
    endclass

endpackage

[tb/text_console_writer_tb.sv]
// testbench for the text console writer: directed and random commands checked beat by beat
`timescale 1ns / 1ps

module text_console_writer_tb;
    import tcw_pkg::*;
    import console_tracker_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int BLOCKS          = 6;
    localparam int ITEMS_PER_BLOCK = 225;
    localparam int HOLD_AT_ITEM    = 500;     // result side freezes once this many went in
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;      // leave plenty of room for a stray beat
    localparam int TIMEOUT_NS      = 200_000_000;

    // block inputs, all known from time zero
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [CMD_W-1:0]   i_command     = CMD_PUT;
    logic [CHAR_W-1:0]  i_char_code   = '0;
    logic [RIDX_W-1:0]  i_read_index  = '0;
    logic               i_out_stall   = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [COLOR_W-1:0] i_cfg_wr_data = COLOR_RESET;

    // block outputs
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [ROW_OUT_W-1:0] o_cursor_row;
    logic [COL_OUT_W-1:0] o_cursor_col;
    logic [POS_OUT_W-1:0] o_cursor_pos;
    logic [CELL_W-1:0]    o_cell_data;
    logic [SCNT_W-1:0]    o_scroll_count;

    // percent of cycles each side sits idle, changed per block of items
    int send_idle_pct = 35;
    int recv_idle_pct = 73;

    screen_tracker screen;

    text_console_writer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_char_code    (i_char_code),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_pos   (o_cursor_pos),
        .o_cell_data    (o_cell_data),
        .o_scroll_count (o_scroll_count),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 0;
    end

    // offer one command beat and hold it until the block takes it;
    // valid stays high on return so back-to-back beats need no second assignment
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                         input logic [RIDX_W-1:0] ridx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_char_code  <= ch;
        i_read_index <= ridx;
        // stall is sampled before this edge's updates land, as the block saw it
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        screen.take_item(cmd, ch, ridx);
    endtask

    // unused payload fields carry random bits so every bit toggles
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        offer(CMD_PUT, ch, RIDX_W'($urandom));
    endtask

    task automatic read_cell(input logic [RIDX_W-1:0] idx);
        offer(CMD_READ, CHAR_W'($urandom), idx);
    endtask

    task automatic erase_back();
        offer(CMD_BKSP, CHAR_W'($urandom), RIDX_W'($urandom));
    endtask

    task automatic wipe_screen();
        offer(CMD_CLEAR, CHAR_W'($urandom), RIDX_W'($urandom));
    endtask

    // color only changes once every outstanding beat is back, so the block is idle
    task automatic set_color(input logic [COLOR_W-1:0] c);
        i_in_valid <= 1'b0;
        while (screen.reports_due.size() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= c;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        screen.color = c;
    endtask

    // random command mix: mostly text with line control, plenty of reads to
    // look back at what was written and at the rows that scrolling refills
    task automatic random_item();
        int unsigned roll;
        int unsigned pos;
        int unsigned back;
        roll = $urandom_range(99);
        pos  = screen.row * COLUMNS + screen.col;
        if (roll < 46) begin
            put_char(CHAR_W'($urandom));
        end else if (roll < 54) begin
            put_char(CH_NEWLINE);
        end else if (roll < 59) begin
            put_char(CH_TAB);
        end else if (roll < 70) begin
            erase_back();
        end else if (roll < 71) begin
            wipe_screen();
        end else if (roll < 84) begin
            // cells just behind the cursor
            back = $urandom_range(2 * COLUMNS);
            read_cell(RIDX_W'(pos > back ? pos - back : 0));
        end else if (roll < 92) begin
            // bottom two rows, where scrolls land
            read_cell(RIDX_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 2 * COLUMNS)));
        end else begin
            // anywhere in the index range, past the end included
            read_cell(RIDX_W'($urandom));
        end
    endtask

    // result side: check each accepted beat, stall at random, and once freeze
    // for a long stretch so the input queue fills and the block stalls its input
    initial begin : result_side
        int unsigned    hold_left;
        bit             hold_done;
        cursor_report_t got;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
                got = {o_cursor_row, o_cursor_col, o_cursor_pos, o_cell_data, o_scroll_count};
                screen.check_report(got);
            end
            if (!hold_done && screen.items_taken >= HOLD_AT_ITEM) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // command side
    initial begin : command_side
        screen = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the block runs a clearing pass now with its input stalled; offer just waits

        // directed part, reset color
        read_cell(RIDX_W'(0));                 // first cell after reset
        read_cell(RIDX_W'(CELL_COUNT - 1));    // last cell
        read_cell('1);                         // past the end reads as zero
        erase_back();                          // backspace at the origin stays put
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_TAB);
        erase_back();
        read_cell(RIDX_W'(2));
        put_char(CH_NEWLINE);
        erase_back();                          // back across the row edge to the last column
        put_char(8'h7E);                       // char in the last column wraps the line
        read_cell(RIDX_W'(COLUMNS - 1));
        erase_back();
        put_char(CH_TAB);                      // tab from the last column wraps as well
        wipe_screen();
        read_cell(RIDX_W'(0));
        read_cell(RIDX_W'(COLUMNS - 1));
        put_char(8'h80);
        read_cell(RIDX_W'(COLUMNS));

        // random part: slow sender with a slower receiver, then swapped, then full rate
        for (int blk = 0; blk < BLOCKS; blk++) begin
            if (blk < 2) begin
                send_idle_pct = 35;
                recv_idle_pct = 73;
            end else if (blk < 4) begin
                send_idle_pct = 73;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // color extremes first, then random settings
            set_color(blk == 0 ? 8'h00 : blk == 1 ? 8'hFF : COLOR_W'($urandom));
            repeat (ITEMS_PER_BLOCK) random_item();
        end

        i_in_valid <= 1'b0;
        while (screen.reports_due.size() != 0) @(posedge i_clk);
        // any stray beat showing up now is flagged by the result side
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d commands and %0d result beats over six color settings",
                 screen.items_taken, screen.reports_seen);
        $display("newline scrolls %0d, wrap scrolls %0d, mismatches %0d",
                 screen.nl_scrolls, screen.wrap_scrolls, screen.mismatches);
        if (screen.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog in case the block stops answering
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d result beats outstanding", screen.reports_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
